[design/bdlr_pkg.sv]
// shared types and constants for the button debouncer with long press and auto repeat
// no dependencies; used by bdlr_update and button_debounce_long_repeat
package bdlr_pkg;

  // field widths
  localparam int BUTTON_ID_W     = 2;
  localparam int NOW_W           = 32;
  localparam int COUNT_W         = 8;
  localparam int DELAY_W         = 16;
  localparam int EVT_W           = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int NUM_BUTTONS_DEF = 4;

  // request codes
  localparam logic REQ_POLL = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // event codes
  localparam logic [EVT_W-1:0] EVT_NONE   = 2'd0;
  localparam logic [EVT_W-1:0] EVT_CLICK  = 2'd1;
  localparam logic [EVT_W-1:0] EVT_LONG   = 2'd2;
  localparam logic [EVT_W-1:0] EVT_REPEAT = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_POLLS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MS     = 2'd2;

  // configuration reset values
  localparam logic [COUNT_W-1:0] STABLE_POLLS_RST  = 8'd2;
  localparam logic [DELAY_W-1:0] LONG_PRESS_MS_RST = 16'd1000;
  localparam logic [DELAY_W-1:0] REPEAT_MS_RST     = 16'd200;

  typedef struct packed {
    logic                   req_type;
    logic [BUTTON_ID_W-1:0] button_id;
    logic                   raw_level;
    logic [NOW_W-1:0]       now_ms;
  } in_item_t;

  typedef struct packed {
    logic [EVT_W-1:0] event_code;
    logic             is_pressed;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] stable_polls;
    logic [DELAY_W-1:0] long_press_ms;
    logic [DELAY_W-1:0] repeat_ms;
  } cfg_t;

  // per-button state entry kept in the state memory
  typedef struct packed {
    logic               accepted_level;
    logic               last_sample;
    logic [COUNT_W-1:0] same_count;
    logic [NOW_W-1:0]   press_time;
    logic [NOW_W-1:0]   repeat_time;
    logic               long_done;
    logic [EVT_W-1:0]   pending_event;
  } entry_t;

  localparam entry_t ENTRY_RST = '{
    accepted_level: 1'b1,
    last_sample:    1'b1,
    same_count:     '0,
    press_time:     '0,
    repeat_time:    '0,
    long_done:      1'b0,
    pending_event:  EVT_NONE
  };

endpackage

[design/button_debounce_long_repeat.sv]
// button debouncer with click, long press and auto repeat events, state in one memory
// throughput: one item per cycle unless the output stalls; an item is registered with its
//   state memory read into the update stage, then its result into the output register; the
//   memory is written back with the update and forwarded when the same button follows
// reset: configuration returns to defaults, entry valid bits clear so every button reads
//   as released with no pending event; no clearing pass, items are taken right away
module button_debounce_long_repeat #(
  parameter int NUM_BUTTONS = bdlr_pkg::NUM_BUTTONS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bdlr_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bdlr_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [bdlr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bdlr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  // configuration registers
  bdlr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stable_polls  <= bdlr_pkg::STABLE_POLLS_RST;
      cfg_r.long_press_ms <= bdlr_pkg::LONG_PRESS_MS_RST;
      cfg_r.repeat_ms     <= bdlr_pkg::REPEAT_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdlr_pkg::CFG_STABLE_POLLS:  cfg_r.stable_polls  <= cfg_wdata[bdlr_pkg::COUNT_W-1:0];
        bdlr_pkg::CFG_LONG_PRESS_MS: cfg_r.long_press_ms <= cfg_wdata;
        bdlr_pkg::CFG_REPEAT_MS:     cfg_r.repeat_ms     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake control
  logic s1_valid_r;
  logic s1_adv;
  logic s1_fire;
  logic in_fire;
  logic out_valid_r;

  assign s1_adv   = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_fire  = in_valid && !in_stall;

  // input address and range check
  logic [bdlr_pkg::BUTTON_ID_W+AW-1:0] in_id_ext;
  logic [AW-1:0]                       in_addr;
  logic                                in_range;

  assign in_id_ext = {{AW{1'b0}}, in_data.button_id};
  assign in_addr   = in_id_ext[AW-1:0];
  assign in_range  = 32'(in_data.button_id) < NUM_BUTTONS;

  // update stage registers
  logic                            s1_req_r;
  logic                            s1_raw_r;
  logic [bdlr_pkg::NOW_W-1:0]      s1_now_r;
  logic [AW-1:0]                   s1_addr_r;
  logic                            s1_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r   <= in_data.req_type;
      s1_raw_r   <= in_data.raw_level;
      s1_now_r   <= in_data.now_ms;
      s1_addr_r  <= in_addr;
      s1_range_r <= in_range;
    end
  end

  // state memory, synchronous read in the accept cycle
  bdlr_pkg::entry_t mem [NUM_BUTTONS];
  bdlr_pkg::entry_t rd_data_r;
  logic             rd_vld_r;
  logic             ent_vld_r [NUM_BUTTONS];
  logic             mem_we;
  bdlr_pkg::entry_t upd_ent;

  assign mem_we = s1_fire && s1_range_r;

  always_ff @(posedge clk) begin
    if (in_fire && in_range) begin
      rd_data_r <= mem[in_addr];
    end
    if (mem_we) begin
      mem[s1_addr_r] <= upd_ent;
    end
  end

  // entry valid bits: an entry never written reads as its reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        ent_vld_r[i] <= 1'b0;
      end
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) begin
        ent_vld_r[s1_addr_r] <= 1'b1;
      end
      if (in_fire && in_range) begin
        rd_vld_r <= ent_vld_r[in_addr];
      end
    end
  end

  // forwarding of the last written entry
  logic             fwd_vld_r;
  logic [AW-1:0]    fwd_addr_r;
  bdlr_pkg::entry_t fwd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else if (mem_we) begin
      fwd_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= upd_ent;
    end
  end

  bdlr_pkg::entry_t cur_ent;

  always_comb begin
    priority if (fwd_vld_r && fwd_addr_r == s1_addr_r) begin
      cur_ent = fwd_data_r;
    end else if (rd_vld_r) begin
      cur_ent = rd_data_r;
    end else begin
      cur_ent = bdlr_pkg::ENTRY_RST;
    end
  end

  // entry update
  logic [bdlr_pkg::EVT_W-1:0] upd_code;
  logic                       upd_pressed;

  bdlr_update u_update (
    .cfg_i       (cfg_r),
    .ent_i       (cur_ent),
    .req_type_i  (s1_req_r),
    .raw_level_i (s1_raw_r),
    .now_i       (s1_now_r),
    .ent_o       (upd_ent),
    .code_o      (upd_code),
    .pressed_o   (upd_pressed)
  );

  // output register
  bdlr_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      if (s1_range_r) begin
        out_data_r.event_code <= upd_code;
        out_data_r.is_pressed <= upd_pressed;
      end else begin
        out_data_r.event_code <= bdlr_pkg::EVT_NONE;
        out_data_r.is_pressed <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled while the pipeline has room");

  a_poll_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_req_r == bdlr_pkg::REQ_POLL) |-> (upd_code == bdlr_pkg::EVT_NONE))
    else $error("poll produced an event code");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> ent_vld_r[$past(s1_addr_r)])
    else $error("written entry not marked valid");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("pipeline not empty after reset");

endmodule

[design/bdlr_update.sv]
// next-state logic for one button entry: debounce, click, long press, repeat, read-clear
// depends on bdlr_pkg
module bdlr_update (
  input  bdlr_pkg::cfg_t          cfg_i,
  input  bdlr_pkg::entry_t        ent_i,
  input  logic                    req_type_i,
  input  logic                    raw_level_i,
  input  logic [bdlr_pkg::NOW_W-1:0] now_i,
  output bdlr_pkg::entry_t        ent_o,
  output logic [bdlr_pkg::EVT_W-1:0] code_o,
  output logic                    pressed_o
);

  bdlr_pkg::entry_t                ent;
  logic                            level_before;
  logic [bdlr_pkg::NOW_W-1:0]      held;
  logic [bdlr_pkg::NOW_W-1:0]      since_rep;
  logic [bdlr_pkg::EVT_W-1:0]      code;

  always_comb begin
    ent          = ent_i;
    code         = bdlr_pkg::EVT_NONE;
    level_before = ent_i.accepted_level;
    held         = '0;
    since_rep    = '0;
    if (req_type_i == bdlr_pkg::REQ_POLL) begin
      // run-length count of equal samples, saturating at the limit
      if (raw_level_i == ent.last_sample) begin
        if (ent.same_count < cfg_i.stable_polls) begin
          ent.same_count = ent.same_count + 8'd1;
        end
      end else begin
        ent.same_count  = '0;
        ent.last_sample = raw_level_i;
      end
      // accept level once the run is long enough
      if (ent.same_count >= cfg_i.stable_polls) begin
        ent.accepted_level = raw_level_i;
        if (level_before && !raw_level_i) begin
          ent.press_time  = now_i;
          ent.repeat_time = now_i;
          ent.long_done   = 1'b0;
        end else if (!level_before && raw_level_i) begin
          if (!ent.long_done) begin
            ent.pending_event = bdlr_pkg::EVT_CLICK;
          end
        end
      end
      // long press and auto repeat while held
      if (!ent.accepted_level) begin
        held = now_i - ent.press_time;
        if (!ent.long_done && held >= {16'b0, cfg_i.long_press_ms}) begin
          ent.long_done     = 1'b1;
          ent.pending_event = bdlr_pkg::EVT_LONG;
          ent.repeat_time   = now_i;
        end
        since_rep = now_i - ent.repeat_time;
        if (ent.long_done && since_rep >= {16'b0, cfg_i.repeat_ms}) begin
          ent.repeat_time   = now_i;
          ent.pending_event = bdlr_pkg::EVT_REPEAT;
        end
      end
    end else begin
      // read and clear the pending slot
      code              = ent.pending_event;
      ent.pending_event = bdlr_pkg::EVT_NONE;
    end
  end

  assign ent_o     = ent;
  assign code_o    = code;
  assign pressed_o = ~ent.accepted_level;

endmodule
